// ----- hdl/blle_pkg.sv -----
// Package: shared types, codes and defaults for the linked list engine.
`default_nettype none
package blle_pkg;
  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefDataWidth = 32;

  localparam logic [2:0] OpInsFront = 3'd0;
  localparam logic [2:0] OpInsBack  = 3'd1;
  localparam logic [2:0] OpInsPos   = 3'd2;
  localparam logic [2:0] OpDelFront = 3'd3;
  localparam logic [2:0] OpDelBack  = 3'd4;
  localparam logic [2:0] OpDelPos   = 3'd5;
  localparam logic [2:0] OpDelValue = 3'd6;
  localparam logic [2:0] OpSearch   = 3'd7;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEmpty    = 3'd1;
  localparam logic [2:0] StRange    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] found_position;
    logic [4:0] list_length;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, start walk at head
    logic rd;        // issue read of current node
    logic step;      // advance cur to next (prev <= cur)
    logic ins;       // link new node after prev (or head if prev nil)
    logic del;       // unlink cur (after prev)
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_nil;
    logic match;
    logic full;
    logic empty;
  } sts_t;
endpackage
`default_nettype wire

// ----- hdl/blle_datapath.sv -----
// Datapath: node pool memories, walk pointers, free map and count.
`default_nettype none
module blle_datapath #(
  parameter int unsigned CAPACITY   = blle_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = blle_pkg::DefDataWidth,
  localparam int unsigned IW = $clog2(CAPACITY + 1),
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  blle_pkg::req_t       req_i,
  input  blle_pkg::cmd_t       cmd_i,
  output blle_pkg::sts_t       sts_o,
  output logic [IW-1:0]        count_o
);
  import blle_pkg::*;
  localparam logic [IW-1:0] Nil = IW'(CAPACITY);

  logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic [IW-1:0]         nxt_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_val_q;
  logic [IW-1:0]         rd_nxt_q;
  logic [IW-1:0] head_q, head_d, cur_q, cur_d, prev_q, prev_d, cnt_q, cnt_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic [DATA_WIDTH-1:0] key_q;
  logic [IW-1:0] free_idx, nxt_fol;
  logic [AW-1:0] waddr;
  logic [IW-1:0] wdata;
  logic          we;

  always_comb begin
    free_idx = Nil;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = IW'(i);
    end
  end

  assign nxt_fol = (rd_nxt_q >= Nil) ? Nil : rd_nxt_q;

  always_comb begin
    head_d = head_q; cur_d = cur_q; prev_d = prev_q; cnt_d = cnt_q; used_d = used_q;
    we = 1'b0; waddr = '0; wdata = '0;
    if (cmd_i.load) begin
      cur_d = head_q; prev_d = Nil;
    end
    if (cmd_i.step) begin
      prev_d = cur_q; cur_d = nxt_fol;
    end
    if (cmd_i.ins) begin
      used_d[free_idx[AW-1:0]] = 1'b1;
      cnt_d = cnt_q + 1'b1;
      if (prev_q == Nil) begin
        head_d = free_idx;
      end else begin
        we = 1'b1; waddr = prev_q[AW-1:0]; wdata = free_idx;
      end
    end
    if (cmd_i.del) begin
      used_d[cur_q[AW-1:0]] = 1'b0;
      cnt_d = cnt_q - 1'b1;
      if (prev_q == Nil) begin
        head_d = nxt_fol;
      end else begin
        we = 1'b1; waddr = prev_q[AW-1:0]; wdata = nxt_fol;
      end
    end
  end

  // ins: new node's next is cur (prev's old next after the step) or the old head if prev is nil
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) key_q <= DATA_WIDTH'(req_i.value);
    if (cmd_i.rd) begin
      rd_val_q <= val_mem[cur_q[AW-1:0]];
      rd_nxt_q <= nxt_mem[cur_q[AW-1:0]];
    end
    if (we) nxt_mem[waddr] <= wdata;
    if (cmd_i.ins) begin
      val_mem[free_idx[AW-1:0]] <= key_q;
      nxt_mem[free_idx[AW-1:0]] <= (prev_q == Nil) ? head_q : cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= Nil; cur_q <= Nil; prev_q <= Nil; cnt_q <= '0; used_q <= '0;
    end else begin
      head_q <= head_d; cur_q <= cur_d; prev_q <= prev_d; cnt_q <= cnt_d;
      used_q <= used_d;
    end
  end

  assign sts_o.cur_nil = (cur_q >= Nil);
  assign sts_o.match   = (rd_val_q == key_q);
  assign sts_o.full    = (cnt_q == Nil);
  assign sts_o.empty   = (cnt_q == '0);
  assign count_o       = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Nil)
    else $error("count above capacity");
  a_ins_del: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ins && cmd_i.del)) else $error("insert and delete together");
  a_cnt_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(cnt_q)) else $error("free map and count disagree");
endmodule
`default_nettype wire

// ----- hdl/blle_ctrl.sv -----
// Controller: sequences list walks and link updates per request.
`default_nettype none
module blle_ctrl #(
  parameter int unsigned CAPACITY = blle_pkg::DefCapacity,
  localparam int unsigned IW = $clog2(CAPACITY + 1),
  localparam int unsigned TW = (IW + 1 > 9) ? IW + 1 : 9
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  blle_pkg::req_t    req_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output blle_pkg::rsp_t    rsp_o,
  output blle_pkg::cmd_t    cmd_o,
  input  blle_pkg::sts_t    sts_i,
  input  wire [IW-1:0]      count_i
);
  import blle_pkg::*;
  localparam logic [2:0] SIdle = 3'd0, SDec = 3'd1, SRead = 3'd2, SEval = 3'd3,
                         SAct = 3'd4, SDone = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] op_q;
  logic [TW-1:0] tgt_q, k_q, k_d;     // k: position of cur
  logic [2:0] st_q, st_d;
  logic [IW-1:0] fnd_q, fnd_d;
  logic act_ins_q, act_ins_d;
  logic ovalid_q, ovalid_d;
  logic [TW-1:0] pos_w, cnt_w;
  logic accept;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle) || ovalid_q;
  assign pos_w = TW'(req_i.position);
  assign cnt_w = TW'(count_i);

  always_comb begin
    state_d = state_q; k_d = k_q; st_d = st_q; fnd_d = fnd_q;
    act_ins_d = act_ins_q; ovalid_d = ovalid_q; cmd_o = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      SIdle: if (accept) begin
        cmd_o.load = 1'b1; k_d = TW'(1); fnd_d = '0; st_d = StOk;
        state_d = SDec;
      end
      SDec: begin
        state_d = SDone;
        act_ins_d = (op_q <= OpInsPos);
        if (op_q == OpSearch || op_q == OpDelValue) begin
          if (op_q == OpDelValue && sts_i.empty) st_d = StEmpty;
          else if (sts_i.cur_nil) st_d = StNotFound;
          else begin cmd_o.rd = 1'b1; state_d = SEval; end
        end else if (op_q <= OpInsPos) begin
          if (op_q == OpInsPos && (tgt_q == '0 || tgt_q > cnt_w + 1'b1)) st_d = StRange;
          else if (sts_i.full) st_d = StFull;
          else if (op_q == OpInsFront || tgt_q == TW'(1)) state_d = SAct;
          else begin cmd_o.rd = 1'b1; state_d = SRead; end
        end else begin
          if (sts_i.empty) st_d = StEmpty;
          else if (op_q == OpDelPos && (tgt_q == '0 || tgt_q > cnt_w)) st_d = StRange;
          else begin cmd_o.rd = 1'b1; state_d = (tgt_q == TW'(1)) ? SAct : SRead; end
        end
      end
      // walk: after read of cur at k, step while k+1 < target for ins, k < target for del
      SRead: begin
        if (act_ins_q && k_q + 1'b1 >= tgt_q) begin
          cmd_o.step = 1'b1; state_d = SAct;        // prev = k-th, cur = old next
        end else begin
          cmd_o.step = 1'b1; k_d = k_q + 1'b1; state_d = SEval;
        end
      end
      SEval: begin
        if (op_q >= OpDelValue) begin
          if (sts_i.match) begin
            fnd_d = k_q[IW-1:0];
            if (op_q == OpDelValue) state_d = SAct; else state_d = SDone;
          end else begin
            cmd_o.step = 1'b1; k_d = k_q + 1'b1; state_d = SDec;
          end
        end else if (k_q >= tgt_q) begin cmd_o.rd = 1'b1; state_d = SAct; end
        else begin cmd_o.rd = 1'b1; state_d = SRead; end
      end
      SAct: begin
        if (act_ins_q) cmd_o.ins = 1'b1; else cmd_o.del = 1'b1;
        if (op_q == OpDelValue) fnd_d = '0;
        state_d = SDone;
      end
      SDone: if (!ovalid_q) begin ovalid_d = 1'b1; state_d = SIdle; end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.opcode;
      unique case (req_i.opcode)
        OpInsBack: tgt_q <= cnt_w + 1'b1;
        OpDelBack: tgt_q <= cnt_w;
        OpInsFront, OpDelFront: tgt_q <= TW'(1);
        default: tgt_q <= pos_w;
      endcase
    end
    if (state_q == SDone && !ovalid_q) begin
      rsp_o.status <= st_q;
      rsp_o.found_position <= 5'(fnd_q);
      rsp_o.list_length <= 5'(count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; ovalid_q <= 1'b0; k_q <= '0; st_q <= StOk; fnd_q <= '0;
      act_ins_q <= 1'b0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d; k_q <= k_d; st_q <= st_d;
      fnd_q <= fnd_d; act_ins_q <= act_ins_d;
    end
  end
  assign out_valid_o = ovalid_q;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.ins, cmd_o.del})) else $error("conflicting commands");
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !accept) else $error("accept while busy");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == SDone) else $error("stray result");
endmodule
`default_nettype wire

// ----- hdl/bounded_linked_list_engine.sv -----
// Top level: bounded singly linked list engine.
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | blle_pkg::req_t
// out     | output    | out_valid/out_stall | blle_pkg::rsp_t
// One transfer at a time; a request passes SDec, walks the node memory where needed
// (SRead/SEval per node, or SEval/SDec for searches), then SAct if it changes the list, then SDone.
// The next request is taken the cycle after the result transfers.
// Reset is asynchronous active low; the list comes up empty, no clearing pass.
// A held result stalls the input until its transfer completes.
`default_nettype none
module bounded_linked_list_engine #(
  parameter int unsigned CAPACITY   = blle_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = blle_pkg::DefDataWidth
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid,
  output logic            in_stall,
  input  blle_pkg::req_t  in_data_i,
  output logic            out_valid,
  input  wire             out_stall,
  output blle_pkg::rsp_t  out_data_o
);
  import blle_pkg::*;
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  cmd_t cmd;
  sts_t sts;
  logic [IW-1:0] count;

  blle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall), .req_i(in_data_i),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .rsp_o(out_data_o),
    .cmd_o(cmd), .sts_i(sts), .count_i(count));

  blle_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .count_o(count));
endmodule
`default_nettype wire
